### hw/rtl/ftnc_pkg.sv
// Package with payload types, controller states and the controller command struct.
`timescale 1ns / 1ps
package ftnc_pkg;

  localparam int unsigned CoefW = 17;

  typedef struct packed {
    logic [CoefW-1:0] a_coef;
    logic [CoefW-1:0] b_coef;
  } ftnc_in_t;

  typedef struct packed {
    logic [CoefW-1:0] c_coef;
    logic             last;
  } ftnc_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FWD,
    ST_MUL,
    ST_INV,
    ST_SCALE,
    ST_EMIT
  } ftnc_state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       load;
    logic       fwd_step;
    logic       fwd_first;
    logic       fwd_done;
    logic       inv_step;
    logic       inv_first;
    logic       inv_done;
    logic [3:0] i_idx;
    logic [3:0] j_idx;
    logic       emit;
    logic       emit_last;
  } ftnc_cmd_t;

endpackage

### hw/rtl/fermat_transform_negacyclic_conv.sv
// Top level of the Fermat number transform negacyclic convolver.
`timescale 1ns / 1ps
// Loads VECTOR_LEN coefficient pairs, one transfer per cycle while busy is low.
// After the last pair the block runs a quadratic forward transform (one
// shift-reduce term per cycle for each vector), then an inverse transform
// with scaling and emits the N results; each result appears for one cycle
// with valid high and last on the final one.
// Busy stays high while the final result is on the port.
// The receiver cannot stall, so results must be taken as they come. A new
// vector is loaded only after the previous one's final result; the rate is set by
// the single shift-reduce unit per store.
module fermat_transform_negacyclic_conv #(
  parameter int unsigned FERMAT_EXP = 16,
  parameter int unsigned VECTOR_LEN = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ftnc_pkg::ftnc_in_t  in_data,
  output logic                valid,
  output ftnc_pkg::ftnc_out_t out_data
);
  import ftnc_pkg::*;

  ftnc_cmd_t  cmd;
  logic [3:0] load_idx;

  ftnc_ctrl #(.VECTOR_LEN(VECTOR_LEN)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .load_idx(load_idx), .cmd(cmd), .done(valid)
  );

  ftnc_datapath #(.FERMAT_EXP(FERMAT_EXP), .VECTOR_LEN(VECTOR_LEN)) u_dp (
    .clk(clk), .in_item(in_data), .cmd(cmd), .load_idx(load_idx),
    .out_item(out_data)
  );

endmodule

### hw/rtl/ftnc_datapath.sv
// Datapath: coefficient stores, shift-reduce units, accumulators, multiplier.
`timescale 1ns / 1ps
module ftnc_datapath #(
  parameter int unsigned FERMAT_EXP = 16,
  parameter int unsigned VECTOR_LEN = 16
) (
  input  logic               clk,
  input  ftnc_pkg::ftnc_in_t  in_item,
  input  ftnc_pkg::ftnc_cmd_t cmd,
  input  logic [3:0]         load_idx,
  output ftnc_pkg::ftnc_out_t out_item
);
  import ftnc_pkg::*;

  localparam int unsigned K  = FERMAT_EXP;
  localparam int unsigned CB = 2 * K;
  localparam int unsigned WP = K / VECTOR_LEN;
  localparam int unsigned LG = (VECTOR_LEN >= 16) ? 4 : (VECTOR_LEN >= 8) ? 3 :
                               (VECTOR_LEN >= 4) ? 2 : (VECTOR_LEN >= 2) ? 1 : 0;
  localparam logic [K:0] FM = {1'b1, {(K-1){1'b0}}, 1'b1};
  localparam int unsigned EW = 6;
  localparam int unsigned NCH = (CoefW + K - 1) / K;

  // Exponent steps, all taken modulo 2K.
  localparam logic [EW-1:0] FSTEP0 = EW'(WP % CB);
  localparam logic [EW-1:0] FSTEP2 = EW'((2 * WP) % CB);
  localparam logic [EW-1:0] IBASE  = EW'((CB - WP) % CB);
  localparam logic [EW-1:0] ISTEP  = EW'((2 * (CB - WP)) % CB);

  logic [K:0] va [16];
  logic [K:0] vb [16];
  logic [K:0] vp [16];
  logic [K:0] acc_a, acc_b, acc_c;
  logic [K:0] res;

  // Reduces a 17-bit value modulo F, folding K-bit chunks from the top.
  function automatic logic [K:0] red17(input logic [CoefW-1:0] x);
    logic [NCH*K-1:0] xe;
    logic [K-1:0]     ch;
    logic [K+1:0]     r;
    xe = (NCH*K)'(x);
    r  = '0;
    for (int c = NCH - 1; c >= 0; c--) begin
      ch = xe[c*K +: K];
      r = (K+2)'(ch) + (K+2)'(FM) - r;
      if (r >= (K+2)'(FM)) r = r - (K+2)'(FM);
    end
    return r[K:0];
  endfunction

  function automatic logic [K:0] addm(input logic [K:0] x, input logic [K:0] y);
    logic [K+1:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, FM}) s = s - {1'b0, FM};
    return s[K:0];
  endfunction

  // Sum of two exponents modulo 2K, both already below 2K.
  function automatic logic [EW-1:0] adde(input logic [EW-1:0] x, input logic [EW-1:0] y);
    logic [EW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= (EW+1)'(CB)) s = s - (EW+1)'(CB);
    return s[EW-1:0];
  endfunction

  // v * 2^s mod F, s already below 2K.
  function automatic logic [K:0] shm(input logic [K:0] v, input logic [EW-1:0] s);
    logic [K:0]     w;
    logic [EW-1:0]  ss;
    logic [2*K:0]   t;
    logic [K:0]     lo, hi;
    logic [K+1:0]   r;
    w = v; ss = s;
    if (ss >= EW'(K)) begin
      w  = (v == '0) ? '0 : FM - v;
      ss = ss - EW'(K);
    end
    t  = (2*K+1)'(w) << ss;
    lo = {1'b0, t[K-1:0]};
    hi = t[2*K:K];
    if (hi >= FM) hi = hi - FM;
    r = {1'b0, lo} + {1'b0, FM} - {1'b0, hi};
    if (r >= {1'b0, FM}) r = r - {1'b0, FM};
    return r[K:0];
  endfunction

  // Product modulo F: x = hi*2^K + lo = lo - hi; hi itself reduced by same rule.
  function automatic logic [K:0] prodm(input logic [2*K+1:0] p);
    logic [K+1:0] h;
    logic [K+2:0] hr, r;
    h  = p[2*K+1:K];
    hr = (K+3)'(h[K-1:0]) + (K+3)'(FM) - (K+3)'(h[K+1:K]);
    if (hr >= (K+3)'(FM)) hr = hr - (K+3)'(FM);
    r = (K+3)'(p[K-1:0]) + (K+3)'(FM) - hr;
    if (r >= (K+3)'(FM)) r = r - (K+3)'(FM);
    return r[K:0];
  endfunction

  // Exponents (2ij+j)*WP and (2ij+i)*(2K-WP) mod 2K, stepped as j and i advance.
  // Forward: j*f_step with f_step = WP*(2i+1). Inverse: i_base + j*i_step with
  // i_base = i*(2K-WP) and i_step = 2i*(2K-WP).
  logic [EW-1:0] f_step, f_exp, i_base, i_step, i_exp;
  logic [EW-1:0] e_f, e_i;
  assign e_f = cmd.fwd_first ? '0 : f_exp;
  assign e_i = cmd.inv_first ? i_base : i_exp;

  logic [K:0] ta, tb, tc;
  assign ta = shm(va[cmd.j_idx], e_f);
  assign tb = shm(vb[cmd.j_idx], e_f);
  assign tc = shm(vp[cmd.j_idx], e_i);

  logic [2*K+1:0] prod;
  assign prod = (2*K+2)'(acc_a) * (2*K+2)'(acc_b);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va[load_idx] <= red17(in_item.a_coef);
      vb[load_idx] <= red17(in_item.b_coef);
    end
    if (cmd.load) begin
      f_step <= FSTEP0;
      i_base <= '0;
      i_step <= '0;
    end else if (cmd.fwd_done) begin
      f_step <= adde(f_step, FSTEP2);
    end else if (cmd.emit) begin
      i_base <= adde(i_base, IBASE);
      i_step <= adde(i_step, ISTEP);
    end
    if (cmd.fwd_step) begin
      acc_a <= addm(cmd.fwd_first ? '0 : acc_a, ta);
      acc_b <= addm(cmd.fwd_first ? '0 : acc_b, tb);
      f_exp <= adde(e_f, f_step);
    end
    if (cmd.fwd_done) vp[cmd.i_idx] <= prodm(prod);
    if (cmd.inv_step) begin
      acc_c <= addm(cmd.inv_first ? '0 : acc_c, tc);
      i_exp <= adde(e_i, i_step);
    end
    if (cmd.inv_done) res <= shm(acc_c, EW'(CB - LG));
    out_item.c_coef <= CoefW'(res);
    out_item.last   <= cmd.emit_last;
  end

endmodule

### hw/rtl/ftnc_ctrl.sv
// Controller state machine sequencing load, transforms and output.
`timescale 1ns / 1ps
module ftnc_ctrl #(
  parameter int unsigned VECTOR_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic [3:0]         load_idx,
  output ftnc_pkg::ftnc_cmd_t cmd,
  output logic               done
);
  import ftnc_pkg::*;

  localparam logic [3:0] NL = 4'(VECTOR_LEN - 1);

  ftnc_state_t state, state_next;
  logic [3:0] i_cnt, j_cnt, i_cnt_next, j_cnt_next, load_idx_next;
  logic       pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; i_cnt <= '0; j_cnt <= '0; load_idx <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next; i_cnt <= i_cnt_next; j_cnt <= j_cnt_next;
      load_idx <= load_idx_next; pend <= pend_next;
    end
  end

  always_comb begin
    state_next = state; i_cnt_next = i_cnt; j_cnt_next = j_cnt;
    load_idx_next = load_idx;
    case (state)
      ST_LOAD: if (start && !pend) begin
        if (load_idx == NL) begin
          load_idx_next = '0; state_next = ST_FWD; i_cnt_next = '0; j_cnt_next = '0;
        end else load_idx_next = load_idx + 4'd1;
      end
      ST_FWD: if (j_cnt == NL) begin
        j_cnt_next = '0; state_next = ST_MUL;
      end else j_cnt_next = j_cnt + 4'd1;
      ST_MUL: if (i_cnt == NL) begin
        i_cnt_next = '0; state_next = ST_INV;
      end else begin
        i_cnt_next = i_cnt + 4'd1; state_next = ST_FWD;
      end
      ST_INV: if (j_cnt == NL) begin
        j_cnt_next = '0; state_next = ST_SCALE;
      end else j_cnt_next = j_cnt + 4'd1;
      ST_SCALE: state_next = ST_EMIT;
      ST_EMIT: if (i_cnt == NL) begin
        i_cnt_next = '0; state_next = ST_LOAD;
      end else begin
        i_cnt_next = i_cnt + 4'd1; state_next = ST_INV;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.i_idx = i_cnt;
    cmd.j_idx = j_cnt;
    busy = (state != ST_LOAD) || pend;
    cmd.load = (state == ST_LOAD) && start && !pend;
    cmd.fwd_step  = (state == ST_FWD);
    cmd.fwd_first = (state == ST_FWD) && (j_cnt == '0);
    cmd.fwd_done  = (state == ST_MUL);
    cmd.inv_step  = (state == ST_INV);
    cmd.inv_first = (state == ST_INV) && (j_cnt == '0);
    cmd.inv_done  = (state == ST_SCALE);
    cmd.emit      = (state == ST_EMIT);
    cmd.emit_last = (state == ST_EMIT) && (i_cnt == NL);
    pend_next = cmd.emit;
  end

  // Output register in the datapath loads at the end of ST_EMIT, as does pend; strobe lines up.
  assign done = pend;

endmodule
